// ===== rtl/dtth_pkg.sv =====
// ----------------------------------------------------------------------------
// dtth_pkg
// Shared widths, codes, configuration defaults and beat types for the
// double-tap and tap-and-hold detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtth_pkg;

    localparam int ID_BITS       = 16;
    localparam int TIME_BITS     = 31;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int KIND_BITS     = 2;
    localparam int REC_BITS      = 2;

    // event kinds
    localparam logic [KIND_BITS-1:0] KIND_BEGIN  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_END    = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_OTHER  = 2'd3;

    // recognition codes
    localparam logic [REC_BITS-1:0] REC_NONE       = 2'd0;
    localparam logic [REC_BITS-1:0] REC_DOUBLE_TAP = 2'd1;
    localparam logic [REC_BITS-1:0] REC_TAP_HOLD   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_MAX  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAP_MAX  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MIN = 2'd2;

    // configuration reset values
    localparam logic [CFG_DATA_BITS-1:0] TAP_MAX_RST  = 16'd300;
    localparam logic [CFG_DATA_BITS-1:0] GAP_MAX_RST  = 16'd600;
    localparam logic [CFG_DATA_BITS-1:0] HOLD_MIN_RST = 16'd600;

    typedef struct packed {
        logic [KIND_BITS-1:0] event_kind;
        logic [ID_BITS-1:0]   gesture_id;
        logic [TIME_BITS-1:0] timestamp;
        logic                 touch_only;
    } in_beat_t;

    typedef struct packed {
        logic [REC_BITS-1:0] recognized;
        logic                unexpected_event;
    } out_beat_t;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] tap_max;
        logic [CFG_DATA_BITS-1:0] gap_max;
        logic [CFG_DATA_BITS-1:0] hold_min;
    } cfg_t;

endpackage

// ===== rtl/dtth_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// dtth_cfg_regs
// Timing limit registers, written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtth_cfg_regs import dtth_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tap_max  <= TAP_MAX_RST;
            cfg_reg.gap_max  <= GAP_MAX_RST;
            cfg_reg.hold_min <= HOLD_MIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TAP_MAX:  cfg_reg.tap_max  <= cfg_wdata;
                CFG_GAP_MAX:  cfg_reg.gap_max  <= cfg_wdata;
                CFG_HOLD_MIN: cfg_reg.hold_min <= cfg_wdata;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/dtth_core.sv =====
// ----------------------------------------------------------------------------
// dtth_core
// Four-phase gesture machine: one event per step, one interval subtract
// and three limit compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtth_core import dtth_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  in_beat_t  item,
    input  cfg_t      cfg,
    output out_beat_t result
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FIRST_END,
        PH_SECOND_BEGIN,
        PH_RECOGNIZE
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic [ID_BITS-1:0]   first_id_reg, first_id_next;
    logic [TIME_BITS-1:0] first_begin_reg, first_begin_next;
    logic [TIME_BITS-1:0] first_end_reg, first_end_next;
    logic [ID_BITS-1:0]   second_id_reg, second_id_next;
    logic [TIME_BITS-1:0] second_begin_reg, second_begin_next;

    logic [TIME_BITS-1:0] ref_time;
    logic [TIME_BITS:0]   diff;
    logic                 diff_neg;
    logic [TIME_BITS-1:0] diff_mag;
    logic                 over_tap, over_gap, hold_reached;

    // one subtractor, stored time picked by phase
    always_comb begin
        case (phase_reg)
            PH_FIRST_END:    ref_time = first_begin_reg;
            PH_SECOND_BEGIN: ref_time = first_end_reg;
            default:         ref_time = second_begin_reg;
        endcase
    end

    assign diff     = {1'b0, item.timestamp} - {1'b0, ref_time};
    assign diff_neg = diff[TIME_BITS];
    assign diff_mag = diff[TIME_BITS-1:0];

    // negative interval counts as short
    assign over_tap     = !diff_neg && (diff_mag >  TIME_BITS'(cfg.tap_max));
    assign over_gap     = !diff_neg && (diff_mag >  TIME_BITS'(cfg.gap_max));
    assign hold_reached = !diff_neg && (diff_mag >= TIME_BITS'(cfg.hold_min));

    always_comb begin
        phase_next        = phase_reg;
        first_id_next     = first_id_reg;
        first_begin_next  = first_begin_reg;
        first_end_next    = first_end_reg;
        second_id_next    = second_id_reg;
        second_begin_next = second_begin_reg;
        result.recognized       = REC_NONE;
        result.unexpected_event = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.event_kind == KIND_BEGIN) begin
                    first_id_next    = item.gesture_id;
                    first_begin_next = item.timestamp;
                    phase_next       = PH_FIRST_END;
                end
            end
            PH_FIRST_END: begin
                if (item.event_kind == KIND_END) begin
                    if (item.gesture_id != first_id_reg || !item.touch_only || over_tap) begin
                        phase_next = PH_IDLE;
                    end else begin
                        first_end_next = item.timestamp;
                        phase_next     = PH_SECOND_BEGIN;
                    end
                end
            end
            PH_SECOND_BEGIN: begin
                if (item.event_kind != KIND_BEGIN || !item.touch_only) begin
                    phase_next = PH_IDLE;
                end else if (over_gap) begin
                    // late second touch starts over as a first tap
                    first_id_next    = item.gesture_id;
                    first_begin_next = item.timestamp;
                    phase_next       = PH_FIRST_END;
                end else begin
                    second_id_next    = item.gesture_id;
                    second_begin_next = item.timestamp;
                    phase_next        = PH_RECOGNIZE;
                end
            end
            PH_RECOGNIZE: begin
                if (item.gesture_id != second_id_reg || !item.touch_only) begin
                    phase_next = PH_IDLE;
                end else begin
                    case (item.event_kind)
                        KIND_UPDATE: begin
                            if (hold_reached) begin
                                result.recognized = REC_TAP_HOLD;
                                phase_next        = PH_IDLE;
                            end
                        end
                        KIND_END: begin
                            if (!over_tap) begin
                                result.recognized = REC_DOUBLE_TAP;
                            end
                            phase_next = PH_IDLE;
                        end
                        default: begin
                            result.unexpected_event = 1'b1;
                        end
                    endcase
                end
            end
            default: phase_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
        end else if (step) begin
            phase_reg        <= phase_next;
            first_id_reg     <= first_id_next;
            first_begin_reg  <= first_begin_next;
            first_end_reg    <= first_end_next;
            second_id_reg    <= second_id_next;
            second_begin_reg <= second_begin_next;
        end
    end

endmodule

// ===== rtl/double_tap_and_hold_detector.sv =====
// ----------------------------------------------------------------------------
// double_tap_and_hold_detector
// Watches touch gesture events and reports a double tap or a tap-and-hold.
// Every event beat taken on the s_ side gives exactly one result beat on the
// m_ side, in order. One beat is accepted per clock when the m_ side keeps
// up: an accepted beat lands in an input register, the gesture machine works
// on it there, and its result is captured in the output register when the
// beat advances, from where the m_ side takes it. The two register stages
// are the input and output registers; only a single subtract and the limit
// compares sit between them. A result held by m_ready stalls the input
// register, and the s_ side stays open as long as the input register is
// empty or empties in the same cycle. The tap, gap and hold limits are
// written through cfg_we / cfg_index / cfg_wdata; the user must write them
// only while no beat is in flight, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_tap_and_hold_detector import dtth_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // event beats in
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_beat_t                 s_data,
    // result beats out
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_beat_t                m_data,
    // limit registers
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    cfg_t      cfg;
    in_beat_t  in_data_reg;
    logic      in_valid_reg;
    out_beat_t m_data_reg;
    logic      m_valid_reg;
    out_beat_t core_result;
    logic      advance;
    logic      s_accept;

    dtth_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // the input beat moves on whenever the output slot is free or draining
    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    // gesture machine steps once per beat handed to the output register
    dtth_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_data_reg <= s_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= core_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a parked input beat is never lost or overwritten
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input beat dropped while stalled");

    // every beat passed to the machine shows up as a result
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result missing after machine step");

    // a recognition and an unexpected kind never come together
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.recognized != REC_NONE && m_data.unexpected_event))
        else $error("recognition and unexpected flag both set");

endmodule
